### hw/rtl/rxf_pkg.sv
// Shared types and constants for the receive FIFO and packet framer.
package rxf_pkg;

	// Receive ring; the pointer arithmetic wraps naturally, so the depth is a power of two.
	localparam int unsigned FifoDepth = 256;
	localparam int unsigned FifoAw    = $clog2(FifoDepth);

	// Packet store holds PktLimit bytes plus the terminator slot.
	localparam int unsigned PktLimit  = 99;
	localparam int unsigned PktDepth  = PktLimit + 1;
	localparam int unsigned PktAw     = $clog2(PktDepth);

	localparam int unsigned CountMax  = 255;

	typedef enum logic [2:0] {
		OP_RECEIVE     = 3'd0,
		OP_POP         = 3'd1,
		OP_DISCARD     = 3'd2,
		OP_CLEAR_FLAG  = 3'd3,
		OP_READ_PACKET = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_START_A = 3'd0,
		REG_START_B = 3'd1,
		REG_START_C = 3'd2,
		REG_END_A   = 3'd3,
		REG_END_B   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] start_a;
		logic [7:0] start_b;
		logic [7:0] start_c;
		logic [7:0] end_a;
		logic [7:0] end_b;
	} chars_t;

	typedef struct packed {
		logic             step;
		op_t              op;
		logic [7:0]       rx_byte;
		logic [PktAw-1:0] idx;
	} frm_req_t;

endpackage

### hw/rtl/rxf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rxf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/rxf_framer.sv
// Packet framer: start/end detection, packet store and ready flag.
module rxf_framer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rxf_pkg::frm_req_t     req,
	input  rxf_pkg::chars_t       chars,
	output logic                  ready_nxt,
	output logic [7:0]            pkt_data
);

	logic                         active_q;
	logic [rxf_pkg::PktAw-1:0]    fill_q;
	logic [rxf_pkg::PktDepth-1:0] valid_q;
	logic                         ready_q;
	logic                         hit_q;

	logic                         active_n;
	logic [rxf_pkg::PktAw-1:0]    fill_n;
	logic [rxf_pkg::PktDepth-1:0] valid_n;
	logic [rxf_pkg::PktAw-1:0]    fill_inc;
	logic                         take;
	logic                         start_hit;
	logic                         end_hit;
	logic                         we;
	logic [rxf_pkg::PktAw-1:0]    waddr;
	logic                         re;
	logic                         idx_ok;
	logic [7:0]                   ram_rdata;

	assign take      = req.step && (req.op == rxf_pkg::OP_RECEIVE);
	assign re        = req.step && (req.op == rxf_pkg::OP_READ_PACKET);
	assign start_hit = (req.rx_byte == chars.start_a) || (req.rx_byte == chars.start_b) ||
	                   (req.rx_byte == chars.start_c);
	assign end_hit   = (req.rx_byte == chars.end_a) || (req.rx_byte == chars.end_b);
	assign fill_inc  = fill_q + rxf_pkg::PktAw'(1);
	assign idx_ok    = req.idx <= rxf_pkg::PktAw'(rxf_pkg::PktLimit);

	// Entries without a valid bit read as zero; the terminator is written by
	// dropping the valid bit of the slot after the last byte.
	always_comb begin
		active_n  = active_q;
		fill_n    = fill_q;
		valid_n   = valid_q;
		ready_nxt = ready_q;
		we        = 1'b0;
		waddr     = fill_q;
		if (take) begin
			if (!active_q) begin
				if (start_hit) begin
					we         = 1'b1;
					waddr      = '0;
					valid_n[0] = 1'b1;
					active_n   = 1'b1;
					fill_n     = rxf_pkg::PktAw'(1);
				end
			end else begin
				we              = 1'b1;
				valid_n[fill_q] = 1'b1;
				fill_n          = fill_inc;
				if (end_hit || (fill_inc >= rxf_pkg::PktAw'(rxf_pkg::PktLimit))) begin
					valid_n[fill_inc] = 1'b0;
					ready_nxt         = 1'b1;
					active_n          = 1'b0;
				end
			end
		end
		if (req.step && (req.op == rxf_pkg::OP_CLEAR_FLAG)) begin
			ready_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fill_q   <= '0;
			valid_q  <= '0;
			ready_q  <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			active_q <= active_n;
			fill_q   <= fill_n;
			valid_q  <= valid_n;
			ready_q  <= ready_nxt;
			if (req.step) begin
				hit_q <= re && idx_ok && valid_q[req.idx];
			end
		end
	end

	rxf_ram #(
		.WIDTH(8),
		.DEPTH(rxf_pkg::PktDepth)
	) u_pkt_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.rx_byte),
		.re   (re),
		.raddr(req.idx),
		.rdata(ram_rdata)
	);

	assign pkt_data = hit_q ? ram_rdata : 8'd0;

	a_active_fill: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (fill_q != '0) && (fill_q < rxf_pkg::PktAw'(rxf_pkg::PktLimit)))
		else $error("framer fill out of range while packet open");

	a_close_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> ready_q)
		else $error("packet closed without ready flag");

	a_ready_from_close: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(active_q))
		else $error("ready flag rose with no open packet");

endmodule

### hw/rtl/rx_fifo_with_packet_framer.sv
// Top level: input register, receive ring FIFO, framer and result register.
// Throughput: one word per cycle; the only coupling is the result register's stall.
// FIFO and packet store are single-write RAMs with registered read, one access each per word.
// Reset: pointers, framer, ready flag and packet-store valid bits clear at once; no sweep.
// Start/end characters reset to '#', '$', '@', LF and CR.
module rx_fifo_with_packet_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  rx_byte,
	input  logic [6:0]  packet_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        fifo_was_empty,
	output logic [7:0]  fifo_count,
	output logic        packet_ready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic                       valid_s1;
	rxf_pkg::op_t               op_s1;
	logic [7:0]                 byte_s1;
	logic [6:0]                 idx_s1;

	logic                       valid_s2;
	logic                       empty_s2;
	logic [7:0]                 count_s2;
	logic                       ready_s2;
	logic                       fifo_sel_s2;

	logic [rxf_pkg::FifoAw-1:0] wp_q;
	logic [rxf_pkg::FifoAw-1:0] rp_q;
	logic [rxf_pkg::FifoAw-1:0] wp_n;
	logic [rxf_pkg::FifoAw-1:0] rp_n;
	logic [rxf_pkg::FifoAw-1:0] used_n;
	rxf_pkg::chars_t            chars_q;

	logic                       adv;
	logic                       fifo_empty;
	logic                       fifo_full;
	logic                       push;
	logic                       pop;
	logic                       ready_nxt;
	logic [7:0]                 fifo_rdata;
	logic [7:0]                 pkt_data;
	rxf_pkg::frm_req_t          frm_req;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= rxf_pkg::op_t'(operation);
			byte_s1 <= rx_byte;
			idx_s1  <= packet_index;
		end
	end

	// Ring FIFO, one slot kept free
	assign fifo_empty = (wp_q == rp_q);
	assign fifo_full  = ((wp_q + rxf_pkg::FifoAw'(1)) == rp_q);
	assign push       = adv && (op_s1 == rxf_pkg::OP_RECEIVE) && !fifo_full;
	assign pop        = adv && (op_s1 == rxf_pkg::OP_POP) && !fifo_empty;

	always_comb begin
		wp_n = wp_q;
		rp_n = rp_q;
		if (push) begin
			wp_n = wp_q + rxf_pkg::FifoAw'(1);
		end
		if (pop) begin
			rp_n = rp_q + rxf_pkg::FifoAw'(1);
		end
		if (adv && (op_s1 == rxf_pkg::OP_DISCARD)) begin
			rp_n = wp_q;
		end
	end

	assign used_n = wp_n - rp_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			wp_q <= wp_n;
			rp_q <= rp_n;
		end
	end

	rxf_ram #(
		.WIDTH(8),
		.DEPTH(rxf_pkg::FifoDepth)
	) u_fifo_ram (
		.clk  (clk),
		.we   (push),
		.waddr(wp_q),
		.wdata(byte_s1),
		.re   (pop),
		.raddr(rp_q),
		.rdata(fifo_rdata)
	);

	assign frm_req.step    = adv;
	assign frm_req.op      = op_s1;
	assign frm_req.rx_byte = byte_s1;
	assign frm_req.idx     = idx_s1;

	rxf_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (frm_req),
		.chars    (chars_q),
		.ready_nxt(ready_nxt),
		.pkt_data (pkt_data)
	);

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q.start_a <= 8'd35;
			chars_q.start_b <= 8'd36;
			chars_q.start_c <= 8'd64;
			chars_q.end_a   <= 8'd10;
			chars_q.end_b   <= 8'd13;
		end else if (cfg_valid && cfg_ready) begin
			case (rxf_pkg::reg_idx_t'(cfg_index))
				rxf_pkg::REG_START_A: chars_q.start_a <= cfg_data;
				rxf_pkg::REG_START_B: chars_q.start_b <= cfg_data;
				rxf_pkg::REG_START_C: chars_q.start_c <= cfg_data;
				rxf_pkg::REG_END_A:   chars_q.end_a   <= cfg_data;
				rxf_pkg::REG_END_B:   chars_q.end_b   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Result register; read data comes from the RAM output registers, which
	// only load when a word advances, so they hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s2    <= (op_s1 == rxf_pkg::OP_POP) && fifo_empty;
			fifo_sel_s2 <= pop;
			ready_s2    <= ready_nxt;
			count_s2    <= (32'(used_n) > 32'(rxf_pkg::CountMax)) ? 8'(rxf_pkg::CountMax)
			                                                       : 8'(used_n);
		end
	end

	assign out_valid      = valid_s2;
	assign read_data      = fifo_sel_s2 ? fifo_rdata : pkt_data;
	assign fifo_was_empty = empty_s2;
	assign fifo_count     = count_s2;
	assign packet_ready   = ready_s2;

	a_empty_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fifo_was_empty |-> (read_data == 8'd0))
		else $error("pop from empty FIFO returned data");

	a_adv_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced word did not reach result register");

	a_flow_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_stall |-> !in_stall)
		else $error("input stalled while output flows");

endmodule

### bench/tb_rx_fifo_with_packet_framer.sv
`timescale 1ns / 1ps
// Testbench for the receive FIFO and packet framer: directed table, then random packet traffic.
module tb_rx_fifo_with_packet_framer;
	import rxf_pkg::*;

	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;
	localparam logic [2:0] REG_RSVD  = 3'd7;

	typedef struct packed {
		logic [7:0] data;
		logic       empty;
		logic [7:0] count;
		logic       ready;
	} status_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] rx;
		logic [6:0] idx;
		logic       typed;
		status_t    st;
	} dir_row_t;

	// Rows with typed set carry their own status; the others go through the framer model.
	localparam int DirRows = 25;
	localparam dir_row_t DIR_TABLE [DirRows] = '{
		'{OP_POP,         8'h00, 7'd0,   1'b1, '{8'h00, 1'b1, 8'd0, 1'b0}},
		'{OP_READ_PACKET, 8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 8'd0, 1'b0}},
		'{OP_READ_PACKET, 8'h00, 7'd127, 1'b1, '{8'h00, 1'b0, 8'd0, 1'b0}},
		'{OP_RSVD_5,      8'hFF, 7'd127, 1'b1, '{8'h00, 1'b0, 8'd0, 1'b0}},
		'{OP_RSVD_6,      8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 8'd0, 1'b0}},
		'{OP_RSVD_7,      8'hA5, 7'd85,  1'b1, '{8'h00, 1'b0, 8'd0, 1'b0}},
		'{OP_RECEIVE,     8'h23, 7'd0,   1'b1, '{8'h00, 1'b0, 8'd1, 1'b0}},
		'{OP_RECEIVE,     8'hFF, 7'd0,   1'b1, '{8'h00, 1'b0, 8'd2, 1'b0}},
		'{OP_RECEIVE,     8'h24, 7'd0,   1'b0, '0},
		'{OP_RECEIVE,     8'h00, 7'd0,   1'b0, '0},
		'{OP_RECEIVE,     8'h0A, 7'd0,   1'b1, '{8'h00, 1'b0, 8'd5, 1'b1}},
		'{OP_READ_PACKET, 8'h00, 7'd0,   1'b1, '{8'h23, 1'b0, 8'd5, 1'b1}},
		'{OP_READ_PACKET, 8'h00, 7'd4,   1'b0, '0},
		'{OP_READ_PACKET, 8'h00, 7'd5,   1'b0, '0},
		'{OP_READ_PACKET, 8'h00, 7'd99,  1'b0, '0},
		'{OP_READ_PACKET, 8'h00, 7'd100, 1'b1, '{8'h00, 1'b0, 8'd5, 1'b1}},
		'{OP_POP,         8'h00, 7'd0,   1'b1, '{8'h23, 1'b0, 8'd4, 1'b1}},
		'{OP_CLEAR_FLAG,  8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 8'd4, 1'b0}},
		'{OP_RECEIVE,     8'h40, 7'd0,   1'b0, '0},
		'{OP_RECEIVE,     8'h23, 7'd0,   1'b0, '0},
		'{OP_RECEIVE,     8'h0D, 7'd0,   1'b0, '0},
		'{OP_READ_PACKET, 8'h00, 7'd1,   1'b0, '0},
		'{OP_DISCARD,     8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 8'd0, 1'b1}},
		'{OP_POP,         8'h00, 7'd0,   1'b1, '{8'h00, 1'b1, 8'd0, 1'b1}},
		'{OP_RECEIVE,     8'h0A, 7'd0,   1'b0, '0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] operation = OP_RECEIVE;
	logic [7:0] rx_byte = 8'h00;
	logic [6:0] packet_index = 7'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_data;
	logic       fifo_was_empty;
	logic [7:0] fifo_count;
	logic       packet_ready;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = REG_START_A;
	logic [7:0] cfg_data = 8'h00;

	// framer/FIFO model state
	chars_t           chars;
	logic [7:0]       ring_mem [FifoDepth];
	logic [7:0]       ring_wr;
	logic [7:0]       ring_rd;
	logic             frame_open;
	logic [PktAw-1:0] frame_fill;
	logic [7:0]       frame_mem [PktDepth];
	logic             frame_done;

	status_t    status_due_q [$];
	int         words_sent = 0;
	int         mismatches = 0;
	bit         quiet = 1'b0;

	rx_fifo_with_packet_framer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.rx_byte(rx_byte),
		.packet_index(packet_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.fifo_was_empty(fifo_was_empty),
		.fifo_count(fifo_count),
		.packet_ready(packet_ready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic status_t framer_fifo_step(input logic [2:0] op, input logic [7:0] b,
			input logic [6:0] idx);
		status_t    r;
		logic [7:0] nxt;
		r = '0;
		case (op)
			OP_RECEIVE: begin
				// full ring drops the byte, the framer still sees it
				nxt = ring_wr + 8'd1;
				if (nxt != ring_rd) begin
					ring_mem[ring_wr] = b;
					ring_wr = nxt;
				end
				if (!frame_open) begin
					if (b == chars.start_a || b == chars.start_b || b == chars.start_c) begin
						frame_open = 1'b1;
						frame_mem[0] = b;
						frame_fill = PktAw'(1);
					end
				end else begin
					if (frame_fill <= PktAw'(PktLimit)) begin
						frame_mem[frame_fill] = b;
						frame_fill++;
					end
					if (b == chars.end_a || b == chars.end_b ||
							frame_fill >= PktAw'(PktLimit)) begin
						if (frame_fill <= PktAw'(PktLimit))
							frame_mem[frame_fill] = 8'h00;
						frame_done = 1'b1;
						frame_open = 1'b0;
					end
				end
			end
			OP_POP: begin
				if (ring_rd == ring_wr) begin
					r.empty = 1'b1;
				end else begin
					r.data = ring_mem[ring_rd];
					ring_rd = ring_rd + 8'd1;
				end
			end
			OP_DISCARD: ring_rd = ring_wr;
			OP_CLEAR_FLAG: frame_done = 1'b0;
			OP_READ_PACKET: begin
				if (idx <= 7'(PktLimit))
					r.data = frame_mem[idx];
			end
			default: ;
		endcase
		r.count = ring_wr - ring_rd;
		r.ready = frame_done;
		return r;
	endfunction

	function automatic logic [7:0] pick_start();
		case ($urandom_range(2))
			0: return chars.start_a;
			1: return chars.start_b;
			default: return chars.start_c;
		endcase
	endfunction

	function automatic logic [7:0] pick_body();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == chars.end_a || b == chars.end_b);
		return b;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic issue(input logic [2:0] op, input logic [7:0] b, input logic [6:0] idx,
			input logic typed = 1'b0, input status_t given = '0);
		status_t due;
		while (!quiet && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		packet_index <= idx;
		do
			@(posedge clk);
		while (in_stall);
		due = framer_fifo_step(op, b, idx);
		status_due_q.push_back(typed ? given : due);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] which, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (which)
			REG_START_A: chars.start_a = value;
			REG_START_B: chars.start_b = value;
			REG_START_C: chars.start_c = value;
			REG_END_A:   chars.end_a = value;
			REG_END_B:   chars.end_b = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_chars(input chars_t c);
		cfg_write(REG_START_A, c.start_a);
		cfg_write(REG_START_B, c.start_b);
		cfg_write(REG_RSVD, 8'($urandom_range(255)));
		cfg_write(REG_START_C, c.start_c);
		cfg_write(REG_END_A, c.end_a);
		cfg_write(REG_END_B, c.end_b);
		cfg_valid <= 1'b0;
	endtask

	// drain all results, then hold the input idle for a while before touching config
	task automatic settle();
		in_valid <= 1'b0;
		while (status_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_packet(input int len);
		int k;
		issue(OP_RECEIVE, pick_start(), 7'($urandom_range(127)));
		for (int i = 0; i < len; i++) begin
			k = $urandom_range(99);
			if (k < 30)
				issue(OP_POP, 8'($urandom_range(255)), 7'($urandom_range(127)));
			else if (k < 38)
				issue(OP_READ_PACKET, 8'($urandom_range(255)), 7'($urandom_range(len + 1)));
			issue(OP_RECEIVE, pick_body(), 7'($urandom_range(127)));
		end
		// some packets are left open on purpose
		if ($urandom_range(99) < 85)
			issue(OP_RECEIVE, $urandom_range(1) ? chars.end_a : chars.end_b, 7'd0);
		repeat ($urandom_range(3, 1))
			issue(OP_READ_PACKET, 8'($urandom_range(255)), 7'($urandom_range(len + 2)));
		if ($urandom_range(1))
			issue(OP_CLEAR_FLAG, 8'($urandom_range(255)), 7'($urandom_range(127)));
	endtask

	task automatic run_random(input int n);
		int stop;
		stop = words_sent + n;
		while (words_sent < stop) begin
			if ($urandom_range(99) < 70) begin
				send_packet($urandom_range(99) < 8 ? $urandom_range(105, 90) : $urandom_range(12, 1));
			end else begin
				repeat ($urandom_range(6, 1))
					issue(3'($urandom_range(7)), 8'($urandom_range(255)),
						7'($urandom_range(127)));
			end
		end
	endtask

	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 24);
	end

	always @(posedge clk) begin : status_check
		status_t seen;
		status_t due;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{read_data, fifo_was_empty, fifo_count, packet_ready};
			if (status_due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word data=%0d empty=%0d count=%0d ready=%0d",
						$realtime, seen.data, seen.empty, seen.count, seen.ready);
			end else begin
				due = status_due_q.pop_front();
				if (seen.data !== due.data || seen.empty !== due.empty ||
						seen.count !== due.count || seen.ready !== due.ready) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: exp data=%0d empty=%0d count=%0d ready=%0d, got %0d %0d %0d %0d",
							$realtime, due.data, due.empty, due.count, due.ready,
							seen.data, seen.empty, seen.count, seen.ready);
				end
			end
		end
	end

	initial begin
		chars = '{8'd35, 8'd36, 8'd64, 8'd10, 8'd13};
		ring_wr = 8'd0;
		ring_rd = 8'd0;
		frame_open = 1'b0;
		frame_fill = '0;
		frame_done = 1'b0;
		frame_mem = '{default: 8'h00};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DirRows; i++)
			issue(DIR_TABLE[i].op, DIR_TABLE[i].rx, DIR_TABLE[i].idx, DIR_TABLE[i].typed,
				DIR_TABLE[i].st);
		run_random(30);

		settle();
		apply_chars('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
		// overrun the ring and run one packet into the length limit
		issue(OP_RECEIVE, pick_start(), 7'd0);
		repeat (260)
			issue(OP_RECEIVE, pick_body(), 7'($urandom_range(127)));
		run_random(30);

		settle();
		quiet = 1'b1;
		apply_chars('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
		run_random(30);

		settle();
		quiet = 1'b0;
		apply_chars('{8'h7E, 8'h01, 8'hC3, 8'h7F, 8'h80});
		run_random(30);

		in_valid <= 1'b0;
		while (status_due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
